@@ rtl/aes_pkg.sv @@
// AES core package: opcodes, controller states, S-box tables and GF(2^8) helpers.
// Used by the controller, datapath, top level and testbench.
package aes_pkg;

  localparam int unsigned MaxRoundsDefault = 14;
  localparam int unsigned MinRounds        = 10;
  localparam int unsigned OpWidth          = 2;
  localparam int unsigned SlotWidth        = 4;
  localparam int unsigned RoundWidth       = 4;
  localparam int unsigned BlockWidth       = 128;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ENCRYPT = 2'd1,
    OP_DECRYPT = 2'd2,
    OP_NONE    = 2'd3
  } aes_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY0,
    ST_ROUND,
    ST_LAST,
    ST_OUT
  } aes_state_e;

  // Datapath commands from the controller
  typedef struct packed {
    logic load_block;  // capture input block
    logic add_key;     // state ^= key (initial addition)
    logic round;       // run one full round with key
    logic last;        // final round (no mix)
    logic decrypt;     // inverse direction
  } aes_cmd_t;

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[x];
  endfunction

endpackage

@@ rtl/aes_ram.sv @@
// Generic single-port-write RAM with registered read.
// No dependencies.
module aes_ram #(
  parameter int unsigned Width = 128,
  parameter int unsigned Depth = 15
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/aes_datapath.sv @@
// AES round datapath: state register and one full round per cycle.
// Depends on aes_pkg.
module aes_datapath (
  input  logic                          clk_i,
  input  aes_pkg::aes_cmd_t             cmd_i,
  input  logic [aes_pkg::BlockWidth-1:0] block_i,
  input  logic [aes_pkg::BlockWidth-1:0] key_i,
  output logic [aes_pkg::BlockWidth-1:0] state_o
);
  import aes_pkg::*;

  logic [BlockWidth-1:0] state_q, state_d;
  logic [7:0] b   [16];
  logic [7:0] sh  [16];
  logic [7:0] sb  [16];
  logic [7:0] ak  [16];
  logic [7:0] mx  [16];
  logic [7:0] res [16];
  logic [7:0] kb  [16];

  // Forward: shift, sub, mix, add. Inverse: shift, sub, add, mix.
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      b[k]  = state_q[BlockWidth-1-8*k -: 8];
      kb[k] = key_i[BlockWidth-1-8*k -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (cmd_i.decrypt) begin
          sh[4*((c+r)%4)+r] = b[4*c+r];
        end else begin
          sh[4*c+r] = b[4*((c+r)%4)+r];
        end
      end
    end
    for (int k = 0; k < 16; k++) begin
      sb[k] = cmd_i.decrypt ? inv_sbox(sh[k]) : sbox(sh[k]);
      ak[k] = cmd_i.decrypt ? (sb[k] ^ kb[k]) : sb[k];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        logic [7:0] a0, a1, a2, a3, x2, x4, x8;
        a0 = ak[4*c+r];
        a1 = ak[4*c+((r+1)%4)];
        a2 = ak[4*c+((r+2)%4)];
        a3 = ak[4*c+((r+3)%4)];
        if (cmd_i.decrypt) begin
          // 0e*a0 ^ 0b*a1 ^ 0d*a2 ^ 09*a3
          x2 = xtime(a0 ^ a1);
          x4 = xtime(xtime(a0 ^ a2));
          x8 = xtime(xtime(xtime(a0 ^ a1 ^ a2 ^ a3)));
          mx[4*c+r] = x8 ^ x4 ^ x2 ^ a1 ^ a2 ^ a3;
        end else begin
          x2 = xtime(a0 ^ a1);
          x4 = 8'h00;
          x8 = 8'h00;
          mx[4*c+r] = x2 ^ a1 ^ a2 ^ a3 ^ x4 ^ x8;
        end
      end
    end
    for (int k = 0; k < 16; k++) begin
      if (cmd_i.last) begin
        res[k] = cmd_i.decrypt ? ak[k] : (sb[k] ^ kb[k]);
      end else begin
        res[k] = cmd_i.decrypt ? mx[k] : (mx[k] ^ kb[k]);
      end
    end
  end

  // Load, initial key addition or one round
  always_comb begin
    state_d = state_q;
    if (cmd_i.load_block) begin
      state_d = block_i;
    end else if (cmd_i.add_key) begin
      state_d = state_q ^ key_i;
    end else if (cmd_i.round || cmd_i.last) begin
      for (int k = 0; k < 16; k++) begin
        state_d[BlockWidth-1-8*k -: 8] = res[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
  end

  assign state_o = state_q;

endmodule

@@ rtl/aes_ctrl.sv @@
// AES controller: sequences key reads and rounds, owns the handshakes.
// Depends on aes_pkg.
module aes_ctrl #(
  parameter int unsigned MaxRounds = aes_pkg::MaxRoundsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [aes_pkg::OpWidth-1:0]     opcode_i,
  input  logic [aes_pkg::RoundWidth-1:0]  num_rounds_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [$clog2(MaxRounds+1)-1:0]  key_addr_o,
  output aes_pkg::aes_cmd_t               cmd_o
);
  import aes_pkg::*;

  localparam int unsigned AW = $clog2(MaxRounds + 1);

  aes_state_e state_q, state_d;
  logic [AW-1:0] rnd_q, rnd_d;     // rounds done so far
  logic [AW-1:0] nr_q, nr_d;       // clamped round count
  logic          dec_q, dec_d;
  logic [AW-1:0] nr_clamp;
  aes_op_e       op;

  assign op = aes_op_e'(opcode_i);

  // Clamp the configured count into the supported range
  always_comb begin
    if (num_rounds_i < RoundWidth'(MinRounds)) begin
      nr_clamp = AW'(MinRounds);
    end else if (32'(num_rounds_i) > MaxRounds) begin
      nr_clamp = AW'(MaxRounds);
    end else begin
      nr_clamp = AW'(num_rounds_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q   <= '0;
      nr_q    <= AW'(MinRounds);
      dec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      nr_q    <= nr_d;
      dec_q   <= dec_d;
    end
  end

  // Next state and commands; the key address is issued in the cycle before its use
  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    nr_d        = nr_q;
    dec_d       = dec_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.decrypt = dec_q;
    key_addr_o  = dec_q ? AW'(nr_q - rnd_q) : rnd_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (op == OP_ENCRYPT || op == OP_DECRYPT)) begin
          dec_d = (op == OP_DECRYPT);
          nr_d  = nr_clamp;
          rnd_d = '0;
          cmd_o.load_block = 1'b1;
          key_addr_o = (op == OP_DECRYPT) ? nr_clamp : '0;
          state_d = ST_KEY0;
        end
      end
      ST_KEY0: begin
        cmd_o.add_key = 1'b1;
        rnd_d = AW'(1);
        key_addr_o = dec_q ? AW'(nr_q - AW'(1)) : AW'(1);
        state_d = (nr_q == AW'(1)) ? ST_LAST : ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        rnd_d = rnd_q + AW'(1);
        key_addr_o = dec_q ? AW'(nr_q - rnd_d) : rnd_d;
        if (rnd_d == nr_q) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        cmd_o.last = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/aes_block_cipher_enc_dec_core.sv @@
// Channel     | dir | signals                          | beat contents
// s_axis      | in  | s_axis_tvalid/tready/tdata/tuser | one block or round key
// m_axis      | out | m_axis_tvalid/tready/tdata       | one result block
// cfg         | in  | cfg_valid/cfg_ready/cfg_data     | num_rounds
// An encrypt or decrypt beat loads the block, adds the initial key, runs the rounds
// up to the final one and then holds the result, all done by the single round unit
// reading one key per cycle from the key RAM read port. Load beats give no result.
// Reset clears control only; the key store is undefined until loaded. A stalled
// result holds and blocks new input.
module aes_block_cipher_enc_dec_core #(
  parameter int unsigned MaxRounds = aes_pkg::MaxRoundsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,   // [63:0] data_hi, [127:64] data_lo
  input  logic [5:0]    s_axis_tuser,   // [1:0] opcode, [5:2] key_slot
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata,   // [63:0] result_hi, [127:64] result_lo
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [3:0]    cfg_data        // num_rounds
);
  import aes_pkg::*;

  localparam int unsigned AW = $clog2(MaxRounds + 1);

  logic [RoundWidth-1:0] num_rounds_q;
  logic [AW-1:0]         key_addr;
  logic [BlockWidth-1:0] key_rd, state;
  aes_cmd_t              cmd;
  logic                  key_we;
  logic [SlotWidth-1:0]  slot;
  aes_op_e               op;

  assign op   = aes_op_e'(s_axis_tuser[1:0]);
  assign slot = s_axis_tuser[5:2];

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rounds_q <= RoundWidth'(MinRounds);
    end else if (cfg_valid) begin
      num_rounds_q <= cfg_data;
    end
  end

  // Key store writes, slots past the depth dropped
  assign key_we = s_axis_tvalid && s_axis_tready && (op == OP_LOAD)
                  && (32'(slot) <= MaxRounds);

  aes_ram #(.Width(BlockWidth), .Depth(MaxRounds + 1)) u_keys (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (AW'(slot)),
    .wdata_i ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
    .raddr_i (key_addr),
    .rdata_o (key_rd)
  );

  aes_ctrl #(.MaxRounds(MaxRounds)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .opcode_i     (s_axis_tuser[1:0]),
    .num_rounds_i (num_rounds_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .key_addr_o   (key_addr),
    .cmd_o        (cmd)
  );

  aes_datapath u_dp (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .block_i ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
    .key_i   (key_rd),
    .state_o (state)
  );

  assign m_axis_tdata = {state[63:0], state[127:64]};

  // Input is never taken while a result is pending
  a_no_in_when_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
  // Key writes only while idle
  a_key_we_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_we |-> !cmd.round && !cmd.last) else $error("key write during rounds");
  // Result appears right after the final round
  a_last_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.last |=> m_axis_tvalid) else $error("result missing after final round");

endmodule

@@ dv/tb_aes_block_cipher_enc_dec_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the AES enc/dec core: loads round keys, runs
// encrypt/decrypt blocks under several round counts, checks against a local AES model.
// Depends on aes_pkg and aes_block_cipher_enc_dec_core.
module tb_aes_block_cipher_enc_dec_core;
  import aes_pkg::*;

  typedef struct packed {
    aes_op_e     op;
    logic [3:0]  slot;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        chk;   // typed-in result present
    logic [127:0] want; // {lo, hi}
  } vec_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [5:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [3:0]   cfg_data = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned err_cnt = 0;

  logic [127:0] key_store [15]; // byte 0 in bits [127:120]
  logic [3:0]   rounds_reg;
  logic [127:0] blocks_due [$]; // {lo, hi} as seen on tdata
  vec_t         dir_tbl [$];

  aes_block_cipher_enc_dec_core u_top (.*);

  always #5 clk_i = ~clk_i;

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // GF(2^8) multiply
  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [7:0] gf_inv(logic [7:0] x);
    logic [7:0] r, b;
    r = 8'h01;
    b = x;
    for (int e = 254; e != 0; e >>= 1) begin
      if (e & 1) r = gf_mul(r, b);
      b = gf_mul(b, b);
    end
    return r;
  endfunction

  function automatic logic [7:0] rol8(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] sub_byte(logic [7:0] x, bit inv);
    logic [7:0] i;
    if (inv) begin
      i = rol8(x, 1) ^ rol8(x, 3) ^ rol8(x, 6) ^ 8'h05;
      return gf_inv(i);
    end
    i = gf_inv(x);
    return i ^ rol8(i, 1) ^ rol8(i, 2) ^ rol8(i, 3) ^ rol8(i, 4) ^ 8'h63;
  endfunction

  // one AES transform; st byte k sits at bits [127-8k -: 8]
  function automatic logic [127:0] aes_block(logic [127:0] st, bit dec, int nr);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] m [4];
    logic [127:0] k;
    int rnd;
    for (int i = 0; i < 16; i++) b[i] = st[127 - 8*i -: 8];
    if (dec) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else     m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int step = 0; step <= nr; step++) begin
      rnd = dec ? nr - step : step;
      if (step > 0) begin
        // shift rows, then substitute
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++)
            if (dec) t[4*((c + r) % 4) + r] = b[4*c + r];
            else     t[4*c + r] = b[4*((c + r) % 4) + r];
        for (int i = 0; i < 16; i++) b[i] = sub_byte(t[i], dec);
        // forward mixes before the key add
        if (!dec && step < nr) begin
          for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
              t[r] = 8'h00;
              for (int j = 0; j < 4; j++) t[r] ^= gf_mul(m[(j + 4 - r) % 4], b[4*c + j]);
            end
            for (int r = 0; r < 4; r++) b[4*c + r] = t[r];
          end
        end
      end
      k = key_store[rnd];
      for (int i = 0; i < 16; i++) b[i] ^= k[127 - 8*i -: 8];
      if (dec && step > 0 && step < nr) begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) begin
            t[r] = 8'h00;
            for (int j = 0; j < 4; j++) t[r] ^= gf_mul(m[(j + 4 - r) % 4], b[4*c + j]);
          end
          for (int r = 0; r < 4; r++) b[4*c + r] = t[r];
        end
      end
    end
    for (int i = 0; i < 16; i++) st[127 - 8*i -: 8] = b[i];
    return st;
  endfunction

  // update key store or queue the expected block
  function automatic void predict_beat(aes_op_e op, logic [3:0] slot,
                                       logic [63:0] hi, logic [63:0] lo);
    logic [127:0] r;
    int nr;
    nr = (rounds_reg < 10) ? 10 : (rounds_reg > 14) ? 14 : rounds_reg;
    case (op)
      OP_LOAD: begin
        if (slot < 15) key_store[slot] = {hi, lo};
      end
      OP_ENCRYPT, OP_DECRYPT: begin
        r = aes_block({hi, lo}, op == OP_DECRYPT, nr);
        blocks_due.push_back({r[63:0], r[127:64]});
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: MISMATCH %s got %h want %h", $time, what, got, want);
    err_cnt++;
  endtask

  // drive one input beat with random idle before it; valid drops only while idling
  task automatic send_beat(aes_op_e op, logic [3:0] slot, logic [63:0] hi, logic [63:0] lo);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    predict_beat(op, slot, hi, lo);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {lo, hi};
    s_axis_tuser  <= {slot, op};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // drop valid, wait for drain, then write num_rounds
  task automatic set_rounds(logic [3:0] v);
    s_axis_tvalid <= 1'b0;
    while (blocks_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    rounds_reg = v;
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_all_keys();
    for (int s = 0; s < 15; s++)
      send_beat(OP_LOAD, 4'(s), {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  // result side: random stall, compare on accept
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (blocks_due.size() == 0) begin
          report_mismatch("unexpected block hi", m_axis_tdata[63:0], '0);
        end else begin
          if (m_axis_tdata[63:0] !== blocks_due[0][63:0])
            report_mismatch("result_hi", m_axis_tdata[63:0], blocks_due[0][63:0]);
          if (m_axis_tdata[127:64] !== blocks_due[0][127:64])
            report_mismatch("result_lo", m_axis_tdata[127:64], blocks_due[0][127:64]);
          void'(blocks_due.pop_front());
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    vec_t v;
    int n;
    aes_op_e op;
    rounds_reg = 4'd10;
    // FIPS-197 AES-128 round keys for key 000102..0f
    key_store[0] = '0;
    dir_tbl = '{
      '{OP_LOAD, 4'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b0, '0},
      '{OP_LOAD, 4'd1, 64'hd6aa74fdd2af72fa, 64'hdaa678f1d6ab76fe, 1'b0, '0},
      '{OP_LOAD, 4'd2, 64'hb692cf0b643dbdf1, 64'hbe9bc5006830b3fe, 1'b0, '0},
      '{OP_LOAD, 4'd3, 64'hb6ff744ed2c2c9bf, 64'h6c590cbf0469bf41, 1'b0, '0},
      '{OP_LOAD, 4'd4, 64'h47f7f7bc95353e03, 64'hf96c32bcfd058dfd, 1'b0, '0},
      '{OP_LOAD, 4'd5, 64'h3caaa3e8a99f9deb, 64'h50f3af57adf622aa, 1'b0, '0},
      '{OP_LOAD, 4'd6, 64'h5e390f7df7a69296, 64'ha7553dc10aa31f6b, 1'b0, '0},
      '{OP_LOAD, 4'd7, 64'h14f9701ae35fe28c, 64'h440adf4d4ea9c026, 1'b0, '0},
      '{OP_LOAD, 4'd8, 64'h47438735a41c65b9, 64'he016baf4aebf7ad2, 1'b0, '0},
      '{OP_LOAD, 4'd9, 64'h549932d1f0855768, 64'h1093ed9cbe2c974e, 1'b0, '0},
      '{OP_LOAD, 4'd10, 64'h13111d7fe3944a17, 64'hf307a78b4d2b30c5, 1'b0, '0},
      '{OP_ENCRYPT, 4'd0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
        {64'hd8cd_b780_70b4_c55a, 64'h69c4_e0d8_6a7b_0430}},
      '{OP_DECRYPT, 4'd0, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1,
        {64'h8899_aabb_ccdd_eeff, 64'h0011_2233_4455_6677}},
      '{OP_NONE, 4'd0, 64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, '0},
      '{OP_LOAD, 4'd15, 64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, '0},
      '{OP_ENCRYPT, 4'hf, 64'h0, 64'h0, 1'b0, '0},
      '{OP_ENCRYPT, 4'h0, 64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, '0},
      '{OP_DECRYPT, 4'h5, 64'h0, 64'hffffffffffffffff, 1'b0, '0}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 35;
    recv_idle_pct = 66;

    // directed table; known-answer rows also cross-check the predictor
    foreach (dir_tbl[i]) begin
      v = dir_tbl[i];
      send_beat(v.op, v.slot, v.hi, v.lo);
      if (v.chk && blocks_due[$] !== v.want)
        report_mismatch("known answer", blocks_due[$][63:0], v.want[63:0]);
    end

    // random phases over round counts, extremes and out-of-range values
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin send_idle_pct = 66; recv_idle_pct = 35; end
      if (ph == 6) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      case (ph % 9)
        0: set_rounds(4'd14);
        1: set_rounds(4'd12);
        2: set_rounds(4'd0);
        3: set_rounds(4'd15);
        4: set_rounds(4'd11);
        5: set_rounds(4'd13);
        6: set_rounds(4'd10);
        7: set_rounds(4'd9);
        default: set_rounds(4'd14);
      endcase
      load_all_keys();
      for (n = 0; n < 74; n++) begin
        case ($urandom_range(9))
          0: op = OP_LOAD;
          1: op = OP_NONE;
          2, 3, 4, 5: op = OP_ENCRYPT;
          default: op = OP_DECRYPT;
        endcase
        send_beat(op, 4'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
      end
    end

    s_axis_tvalid <= 1'b0;
    while (blocks_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/aes_pkg.sv
rtl/aes_ram.sv
rtl/aes_datapath.sv
rtl/aes_ctrl.sv
rtl/aes_block_cipher_enc_dec_core.sv
dv/tb_aes_block_cipher_enc_dec_core.sv
